// File: rtl/bole_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the bounded ordered list engine
// used by bole_cell and bounded_ordered_list_engine, no dependencies
package bole_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 6;
	localparam int REQ_W    = 3;

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_TAIL  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_TAIL   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd4;

	typedef logic [1:0] cmd_kind_t;

	localparam cmd_kind_t CMD_HOLD  = 2'd0;
	localparam cmd_kind_t CMD_OPEN  = 2'd1;
	localparam cmd_kind_t CMD_CLOSE = 2'd2;
	localparam cmd_kind_t CMD_WRITE = 2'd3;

	// broadcast to every cell of the row
	typedef struct packed {
		cmd_kind_t        kind;
		logic [IDX_W-1:0] start;
		logic [IDX_W-1:0] tail;
		logic [VAL_W-1:0] wval;
	} cell_cmd_t;

endpackage

// File: rtl/bole_cell.sv
`timescale 1ns / 1ps
// one storage cell of the list row: holds one element, shifts with its neighbors
// depends on bole_pkg
module bole_cell import bole_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] idx,
	input  cell_cmd_t        cmd,
	input  logic [VAL_W-1:0] below,
	input  logic [VAL_W-1:0] above,
	output logic [VAL_W-1:0] value,
	output logic [VAL_W-1:0] tap
);

	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] value_d;

	always_comb begin
		value_d = value_q;
		unique case (cmd.kind)
			CMD_HOLD: begin
				value_d = value_q;
			end
			CMD_OPEN: begin
				// cells above the gap take the word from below
				if (idx == cmd.start) begin
					value_d = cmd.wval;
				end else if (idx > cmd.start) begin
					value_d = below;
				end
			end
			CMD_CLOSE: begin
				value_d = above;
			end
			CMD_WRITE: begin
				if (idx == cmd.start) begin
					value_d = cmd.wval;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;
	assign tap   = (idx == cmd.tail) ? value_q : '0;

endmodule

// File: rtl/bounded_ordered_list_engine.sv
`timescale 1ns / 1ps
// bounded ordered list engine on a row of shifting cells: one request per cycle unless stalled
// the result word is registered and appears in the cycle after the request word is taken
// throughput: one request per cycle; front pushes, front pops and inserts shift the cell row
// a result waiting in the output register does not block the next request if m_tready is high
// reset clears the element count and the output valid; cell contents are not reset
// depends on bole_pkg and bole_cell
module bounded_ordered_list_engine import bole_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // value_in[31:0], position[37:32], zero pad
	input  logic [2:0]  s_tuser,  // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // value_out[31:0], count_out[38:32], zero pad
	output logic        m_tuser   // error_flag[0]
);

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] value_out_q;
	logic [CNT_W-1:0] count_out_q;
	logic             error_q;

	logic [REQ_W-1:0] req;
	logic [VAL_W-1:0] val_in;
	logic [POS_W-1:0] pos;
	logic             accept;
	logic             full;
	logic             empty;
	logic             pos_bad;

	cell_cmd_t        cmd;
	logic [CNT_W-1:0] count_d;
	logic [VAL_W-1:0] result_d;
	logic             err_d;
	logic [VAL_W-1:0] tail_val;

	logic [VAL_W-1:0] vals [CAPACITY];
	logic [VAL_W-1:0] taps [CAPACITY];

	assign req    = s_tuser;
	assign val_in = s_tdata[31:0];
	assign pos    = s_tdata[37:32];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign full    = (count_q >= CNT_W'(CAPACITY));
	assign empty   = (count_q == '0);
	assign pos_bad = ({1'b0, pos} >= count_q);

	always_comb begin
		tail_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail_val = tail_val | taps[i];
		end
	end

	always_comb begin
		cmd.kind  = CMD_HOLD;
		cmd.start = '0;
		cmd.tail  = count_q[IDX_W-1:0] - IDX_W'(1);
		cmd.wval  = val_in;
		count_d   = count_q;
		result_d  = '0;
		err_d     = 1'b0;
		if (accept) begin
			unique case (req)
				REQ_PUSH_FRONT: begin
					if (full) begin
						err_d = 1'b1;
					end else begin
						cmd.kind = CMD_OPEN;
						count_d  = count_q + CNT_W'(1);
					end
				end
				REQ_PUSH_TAIL: begin
					if (full) begin
						err_d = 1'b1;
					end else begin
						cmd.kind  = CMD_WRITE;
						cmd.start = count_q[IDX_W-1:0];
						count_d   = count_q + CNT_W'(1);
					end
				end
				REQ_POP_FRONT: begin
					if (!empty) begin
						cmd.kind = CMD_CLOSE;
						result_d = vals[0];
						count_d  = count_q - CNT_W'(1);
					end
				end
				REQ_POP_TAIL: begin
					if (!empty) begin
						result_d = tail_val;
						count_d  = count_q - CNT_W'(1);
					end
				end
				REQ_INSERT: begin
					if (full || pos_bad) begin
						err_d = 1'b1;
					end else begin
						cmd.kind  = CMD_OPEN;
						cmd.start = pos + IDX_W'(1);
						count_d   = count_q + CNT_W'(1);
					end
				end
				default: begin
					// unused request codes pass through untouched
				end
			endcase
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [VAL_W-1:0] below;
		logic [VAL_W-1:0] above;
		if (g == 0) begin : g_lo
			assign below = '0;
		end else begin : g_lo_n
			assign below = vals[g-1];
		end
		if (g == CAPACITY - 1) begin : g_hi
			assign above = '0;
		end else begin : g_hi_n
			assign above = vals[g+1];
		end
		bole_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(g)),
			.cmd   (cmd),
			.below (below),
			.above (above),
			.value (vals[g]),
			.tap   (taps[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_out_q <= result_d;
			count_out_q <= count_d;
			error_q     <= err_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, count_out_q, value_out_q};
	assign m_tuser  = error_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_err_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && err_d |=> count_q == $past(count_q))
		else $error("refused request changed the count");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req == REQ_PUSH_FRONT && !full |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push front did not grow the list");

	a_empty_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && empty && (req == REQ_POP_FRONT || req == REQ_POP_TAIL)
		|=> value_out_q == '0 && !error_q)
		else $error("pop of empty list returned data");

endmodule

// File: verif/tb_bounded_ordered_list_engine.sv
`timescale 1ns / 1ps
// self-checking testbench for bounded_ordered_list_engine: pushes, pops and inserts
// are checked against a queue-based predictor; depends on bole_pkg and the rtl
module tb_bounded_ordered_list_engine;
	import bole_pkg::*;

	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic [CNT_W-1:0]        count;
		logic                    refused;
	} list_reply_t;

	// tracks list contents and checks every result word in order
	class deque_tracker;
		logic signed [VAL_W-1:0] contents[$];
		list_reply_t             expected_replies[$];
		int unsigned             faults;
		int unsigned             requests_seen;
		int unsigned             replies_checked;
		int unsigned             refusals;
		int unsigned             empty_pops;
		int unsigned             peak_fill;

		function void note_request(logic [REQ_W-1:0] req, logic signed [VAL_W-1:0] val,
				logic [POS_W-1:0] pos);
			list_reply_t r;
			r.value   = '0;
			r.refused = 1'b0;
			requests_seen++;
			case (req)
				REQ_PUSH_FRONT: begin
					if (contents.size() >= CAPACITY) r.refused = 1'b1;
					else contents.push_front(val);
				end
				REQ_PUSH_TAIL: begin
					if (contents.size() >= CAPACITY) r.refused = 1'b1;
					else contents.insert(contents.size(), val);
				end
				REQ_POP_FRONT: begin
					if (contents.size() > 0) r.value = contents.pop_front();
					else empty_pops++;
				end
				REQ_POP_TAIL: begin
					if (contents.size() > 0) begin
						r.value = contents[$];
						contents.delete(contents.size() - 1);
					end else begin
						empty_pops++;
					end
				end
				REQ_INSERT: begin
					if (contents.size() >= CAPACITY || int'(pos) >= contents.size())
						r.refused = 1'b1;
					else
						contents.insert(int'(pos) + 1, val);
				end
				default: ;
			endcase
			if (r.refused) refusals++;
			if (contents.size() > peak_fill) peak_fill = contents.size();
			r.count = CNT_W'(contents.size());
			expected_replies.insert(expected_replies.size(), r);
		endfunction

		function void check_reply(logic [39:0] tdata, logic tuser);
			list_reply_t             want;
			logic signed [VAL_W-1:0] got_value;
			logic [CNT_W-1:0]        got_count;
			got_value = tdata[31:0];
			got_count = tdata[38:32];
			if (expected_replies.size() == 0) begin
				$display("%0t: result word with nothing pending: value %0d count %0d error %0b",
					$time, got_value, got_count, tuser);
				faults++;
				return;
			end
			want = expected_replies.pop_front();
			replies_checked++;
			if (got_value !== want.value) begin
				$display("%0t: value_out expected %0d actual %0d", $time, want.value, got_value);
				faults++;
			end
			if (got_count !== want.count) begin
				$display("%0t: count_out expected %0d actual %0d", $time, want.count, got_count);
				faults++;
			end
			if (tuser !== want.refused) begin
				$display("%0t: error_flag expected %0b actual %0b", $time, want.refused, tuser);
				faults++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;

	deque_tracker board;
	bit           gaps_on;
	bit           hold_off_req;
	int unsigned  idle_cycles;

	bounded_ordered_list_engine DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// both handshakes sampled here so prediction and checking share one ordering
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			board.note_request(s_tuser, s_tdata[31:0], s_tdata[37:32]);
		if (m_tvalid && m_tready)
			board.check_reply(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("tb_bounded_ordered_list_engine NOT OK");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = gaps_on ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic offer_request(input logic [REQ_W-1:0] req, input logic signed [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {2'b00, pos, val};
		do @(posedge clk); while (!s_tready);
	endtask

	// alternates between filling toward capacity and draining toward empty
	task automatic run_random(input int unsigned n_items);
		int unsigned      done;
		int unsigned      depth;
		int unsigned      r;
		bit               draining;
		logic [REQ_W-1:0] req;
		logic [POS_W-1:0] pos;
		done     = 0;
		draining = bit'($urandom_range(0, 1));
		while (done < n_items) begin
			depth = board.contents.size();
			if (!draining && depth >= CAPACITY && $urandom_range(0, 3) == 0) draining = 1'b1;
			if (draining && depth == 0 && $urandom_range(0, 2) == 0) draining = 1'b0;
			if ($urandom_range(0, 199) == 0) draining = !draining;
			r   = $urandom_range(0, 99);
			pos = POS_W'($urandom_range(0, 63));
			if (r >= 96) req = REQ_W'($urandom_range(5, 7));
			else if (draining) begin
				if (r < 8) req = REQ_PUSH_FRONT;
				else if (r < 16) req = REQ_PUSH_TAIL;
				else if (r < 24) req = REQ_INSERT;
				else if (r < 60) req = REQ_POP_FRONT;
				else req = REQ_POP_TAIL;
			end else begin
				if (r < 35) req = REQ_PUSH_FRONT;
				else if (r < 65) req = REQ_PUSH_TAIL;
				else if (r < 88) req = REQ_INSERT;
				else if (r < 92) req = REQ_POP_FRONT;
				else req = REQ_POP_TAIL;
			end
			// mostly valid insert positions, some at or past the count
			if (req == REQ_INSERT) begin
				if (depth > 0 && $urandom_range(0, 4) != 0)
					pos = POS_W'($urandom_range(0, (depth > 64 ? 64 : depth) - 1));
				else
					pos = POS_W'($urandom_range(depth > 63 ? 63 : depth, 63));
			end
			offer_request(req, pick_value(), pos);
			if (req <= REQ_INSERT) done++;
		end
	endtask

	initial begin
		board        = new();
		gaps_on      = 1'b1;
		hold_off_req = 1'b0;
		idle_cycles  = 0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, unused codes, extremes, inserts at both ends and out of range
		offer_request(REQ_POP_FRONT, 32'h1234_5678, 6'd0);
		offer_request(REQ_POP_TAIL, 32'h0, 6'd63);
		offer_request(REQ_INSERT, 32'h2222_2222, 6'd0);
		offer_request(3'd5, 32'hffff_ffff, 6'd63);
		offer_request(3'd6, 32'h0, 6'd0);
		offer_request(3'd7, 32'h8000_0000, 6'd21);
		offer_request(REQ_PUSH_TAIL, 32'h7fff_ffff, 6'd0);
		offer_request(REQ_PUSH_FRONT, 32'h8000_0000, 6'd63);
		offer_request(REQ_PUSH_TAIL, 32'h0, 6'd42);
		offer_request(REQ_PUSH_FRONT, 32'hffff_ffff, 6'd0);
		offer_request(REQ_INSERT, 32'h5555_aaaa, 6'd0);
		offer_request(REQ_INSERT, 32'haaaa_5555, 6'd4);
		offer_request(REQ_INSERT, 32'h1, 6'd6);
		offer_request(REQ_INSERT, 32'h2, 6'd63);
		offer_request(REQ_POP_FRONT, 32'h0, 6'd0);
		offer_request(REQ_POP_TAIL, 32'h0, 6'd0);
		offer_request(REQ_POP_FRONT, 32'h0, 6'd0);
		offer_request(REQ_POP_TAIL, 32'h0, 6'd0);
		offer_request(REQ_POP_FRONT, 32'h0, 6'd0);
		offer_request(REQ_POP_TAIL, 32'h0, 6'd0);
		offer_request(REQ_POP_TAIL, 32'h0, 6'd0);

		run_random(500);
		// back to back with the receiver stalled at first, so the input backs up
		gaps_on      = 1'b0;
		hold_off_req = 1'b1;
		run_random(400);
		gaps_on = 1'b1;
		run_random(500);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.expected_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d requests sent, %0d result words checked, %0d refused, %0d empty pops",
			board.requests_seen, board.replies_checked, board.refusals, board.empty_pops);
		$display("list filled to %0d of %0d entries; result side held off %0d cycles once",
			board.peak_fill, CAPACITY, HOLD_CYCLES);
		if (board.faults == 0 && board.expected_replies.size() == 0) begin
			$display("tb_bounded_ordered_list_engine OK");
		end else begin
			$display("tb_bounded_ordered_list_engine NOT OK");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/bole_pkg.sv
rtl/bole_cell.sv
rtl/bounded_ordered_list_engine.sv
verif/tb_bounded_ordered_list_engine.sv
